@@ hdl/bac_pkg.sv @@
// types, constants and constant tables for the barometric altitude converter
package bac_pkg;

   localparam int LOG_TABLE_ENTRIES = 256;
   localparam int LOG_IDX_W = $clog2(LOG_TABLE_ENTRIES);
   localparam int LOG_W = 17;
   localparam int POW_STEPS = 16;
   localparam int M_W = 31;

   localparam logic [17:0] EXP_COEF_Q20 = 18'd199544;
   localparam logic [22:0] P0_RESET = 23'd4150272;
   localparam logic [19:0] ALT_FULL_DM = 20'd443300;
   localparam logic [19:0] ALT_MIN_DM = 20'hE7960;
   localparam logic [27:0] ALT_SPAN_DM = 28'd543300;
   localparam logic [15:0] TEMP_OFFSET = 16'd4250;
   localparam logic [16:0] RECIP_THREE = 17'd43691;

   typedef logic [LOG_W-1:0] log_tab_type [0:LOG_TABLE_ENTRIES];
   typedef logic [M_W-1:0] root_tab_type [0:POW_STEPS-1];

   typedef struct packed {
      logic [23:0] pressure;
      logic [14:0] temperature;
      logic        invalid;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [M_W-1:0]    m;
      logic [15:0]       f;
      logic signed [7:0] ip;
   } chain_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   function automatic logic [LOG_W-1:0] log2_bits(input logic [63:0] x_in);
      logic [63:0] x;
      logic [31:0] r;
      x = x_in;
      r = 32'd0;
      for (int k = 0; k < 17; k++) begin
         x = (x * x) >> 30;
         r = r << 1;
         if (x >= (64'd1 << 31)) begin
            r = r | 32'd1;
            x = x >> 1;
         end
      end
      r = (r + 32'd1) >> 1;
      return r[LOG_W-1:0];
   endfunction

   function automatic log_tab_type build_log_tab();
      log_tab_type t;
      for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
         t[i] = log2_bits((64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES));
      end
      t[LOG_TABLE_ENTRIES] = LOG_W'(65536);
      return t;
   endfunction

   function automatic root_tab_type build_root_tab();
      root_tab_type t;
      logic [63:0] s;
      s = isqrt64(64'd1 << 61);
      t[0] = s[M_W-1:0];
      for (int k = 1; k < POW_STEPS; k++) begin
         s = isqrt64({33'd0, t[k-1]} << 30);
         t[k] = s[M_W-1:0];
      end
      return t;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();
   localparam root_tab_type ROOT_TAB = build_root_tab();

endpackage

@@ hdl/bac_log2.sv @@
// two-stage base-2 logarithm in q16 by table interpolation
module bac_log2 (
   input  logic        clock,
   input  logic        en,
   input  logic [22:0] value,
   output logic [20:0] log_q16
);

   logic [4:0]  exp_a_in;
   logic [30:0] norm;
   logic [29:0] frac;
   logic [bac_pkg::LOG_IDX_W-1:0] idx;
   logic [bac_pkg::LOG_IDX_W:0]   idx_hi;
   logic [29:0] rem_a_in;
   logic [bac_pkg::LOG_W-1:0] lo_a_in;
   logic [bac_pkg::LOG_W-1:0] diff_a_in;

   logic [4:0]  exp_a_ff;
   logic [bac_pkg::LOG_W-1:0] lo_a_ff;
   logic [bac_pkg::LOG_W-1:0] diff_a_ff;
   logic [29:0] rem_a_ff;

   logic [4:0]  exp_b_ff;
   logic [bac_pkg::LOG_W-1:0] lo_b_ff;
   logic [bac_pkg::LOG_W+29:0] prod_b_in;
   logic [bac_pkg::LOG_W+29:0] prod_b_ff;

   always_comb begin
      exp_a_in = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (value[i]) exp_a_in = 5'(i);
      end
      norm = 31'(value) << (5'd30 - exp_a_in);
      frac = norm[29:0];
      idx = frac[29 -: bac_pkg::LOG_IDX_W];
      idx_hi = {1'b0, idx} + 1'b1;
      rem_a_in = {frac[29-bac_pkg::LOG_IDX_W:0], {bac_pkg::LOG_IDX_W{1'b0}}};
      lo_a_in = bac_pkg::LOG_TAB[idx];
      diff_a_in = bac_pkg::LOG_TAB[idx_hi] - lo_a_in;
   end

   assign prod_b_in = (bac_pkg::LOG_W+30)'(diff_a_ff) * (bac_pkg::LOG_W+30)'(rem_a_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         exp_a_ff  <= exp_a_in;
         lo_a_ff   <= lo_a_in;
         diff_a_ff <= diff_a_in;
         rem_a_ff  <= rem_a_in;
         exp_b_ff  <= exp_a_ff;
         lo_b_ff   <= lo_a_ff;
         prod_b_ff <= prod_b_in;
      end
   end

   assign log_q16 = {exp_b_ff, 16'd0} + 21'(lo_b_ff) + 21'(prod_b_ff >> 30);

endmodule

@@ hdl/bac_pow_cell.sv @@
// one cell of the power chain: conditional multiply by a root of two
module bac_pow_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  bac_pkg::chain_type          in_data,
   input  logic                        sel,
   input  logic [bac_pkg::M_W-1:0]     root,
   output logic                        out_valid,
   output bac_pkg::chain_type          out_data
);

   logic [61:0] prod;
   logic [61:0] rounded;
   bac_pkg::chain_type data_in;
   bac_pkg::chain_type data_ff;
   logic valid_ff;

   always_comb begin
      prod = 62'(in_data.m) * 62'(root);
      rounded = prod + (62'd1 << 29);
      data_in = in_data;
      if (sel) data_in.m = rounded[30 +: bac_pkg::M_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

@@ hdl/baro_altitude_converter_top.sv @@
// barometric altitude converter top level with stream ports and reference register
// throughput: one item per cycle unless rsp stalls, set by the fully pipelined log, root-chain and scale stages
// the whole pipeline holds while a result waits and rsp_tready is low
// reset clears all valid bits and loads the reference pressure with 1013.25 hPa
module baro_altitude_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_pressure, raw_temperature
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // pressure_q12, temperature_centi, altitude_dm, zero fill
   output logic        rsp_tuser,   // pressure_invalid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [22:0] csr_data     // reference_pressure
);

   logic en;
   logic accept;
   logic [22:0] ref_ff;
   logic [22:0] p0;
   logic [22:0] p_val;
   logic [23:0] p_raw;
   logic [15:0] t_raw;
   logic p_bad;
   logic [15:0] t_mag;
   logic [17:0] t_num;
   logic [31:0] t_div;
   logic [12:0] t_q;
   bac_pkg::side_type side1_in;

   logic [20:0] lp;
   logic [20:0] lp0;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vp_ff, vq_ff, rsp_valid_ff;
   bac_pkg::side_type side1_ff, side2_ff, side3_ff, side4_ff, sidep_ff, sideq_ff;

   logic signed [21:0] d_in;
   logic signed [21:0] d_ff;
   logic signed [40:0] eprod_in;
   logic signed [40:0] eprod_ff;
   logic [43:0] u;
   logic [23:0] yq;
   logic [7:0] ip_u;
   bac_pkg::chain_type chain5_in;
   bac_pkg::chain_type chain5_ff;

   bac_pkg::chain_type link [0:bac_pkg::POW_STEPS];
   logic vld [0:bac_pkg::POW_STEPS];

   bac_pkg::chain_type last;
   logic [7:0] neg;
   logic [38:0] pw_in;
   logic [38:0] pw_ff;
   logic [57:0] qprod_in;
   logic [57:0] qprod_ff;
   logic [57:0] qsum;
   logic [27:0] q;
   logic [19:0] alt_in;
   logic [63:0] rsp_data_ff;
   logic rsp_user_ff;

   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign accept = req_tvalid && en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= bac_pkg::P0_RESET;
      end else if (csr_valid) begin
         ref_ff <= csr_data;
      end
   end

   always_comb begin
      p_raw = req_tdata[23:0];
      t_raw = req_tdata[39:24];
      p_bad = p_raw[23] || (p_raw == 24'd0);
      p_val = p_bad ? 23'd1 : p_raw[22:0];
      p0 = (ref_ff == 23'd0) ? 23'd1 : ref_ff;
      t_mag = t_raw[15] ? 16'(-t_raw) : t_raw;
      t_num = {t_mag, 2'b00} + 18'(t_mag) + 18'd12;
      t_div = 32'(t_num[17:3]) * 32'(bac_pkg::RECIP_THREE);
      t_q = t_div[29:17];
      side1_in.pressure = p_raw;
      side1_in.invalid = p_bad;
      side1_in.temperature = t_raw[15] ? 15'(bac_pkg::TEMP_OFFSET - 16'(t_q))
                                       : 15'(bac_pkg::TEMP_OFFSET + 16'(t_q));
   end

   bac_log2 u_log_p (
      .clock   (clock),
      .en      (en),
      .value   (p_val),
      .log_q16 (lp)
   );

   bac_log2 u_log_p0 (
      .clock   (clock),
      .en      (en),
      .value   (p0),
      .log_q16 (lp0)
   );

   always_comb begin
      d_in = $signed({1'b0, lp}) - $signed({1'b0, lp0});
      eprod_in = d_ff * $signed({1'b0, bac_pkg::EXP_COEF_Q20});
      u = {{3{eprod_ff[40]}}, eprod_ff} + (44'd1 << 42) + (44'd1 << 19);
      yq = u[43:20];
      ip_u = yq[23:16] - 8'd64;
      chain5_in.side = side4_ff;
      chain5_in.m = bac_pkg::M_W'(1) << 30;
      chain5_in.f = yq[15:0];
      chain5_in.ip = $signed(ip_u);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vp_ff <= 1'b0;
         vq_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         vp_ff <= vld[bac_pkg::POW_STEPS];
         vq_ff <= vp_ff;
         rsp_valid_ff <= vq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         side4_ff <= side3_ff;
         d_ff <= d_in;
         eprod_ff <= eprod_in;
         chain5_ff <= chain5_in;
         sidep_ff <= last.side;
         pw_ff <= pw_in;
         sideq_ff <= sidep_ff;
         qprod_ff <= qprod_in;
         rsp_data_ff <= {5'd0, alt_in, sideq_ff.temperature, sideq_ff.pressure};
         rsp_user_ff <= sideq_ff.invalid;
      end
   end

   assign link[0] = chain5_ff;
   assign vld[0] = v5_ff;

   for (genvar k = 0; k < bac_pkg::POW_STEPS; k++) begin : g_cell
      bac_pow_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld[k]),
         .in_data   (link[k]),
         .sel       (link[k].f[bac_pkg::POW_STEPS-1-k]),
         .root      (bac_pkg::ROOT_TAB[k]),
         .out_valid (vld[k+1]),
         .out_data  (link[k+1])
      );
   end

   always_comb begin
      last = link[bac_pkg::POW_STEPS];
      neg = 8'(-last.ip);
      if (!last.ip[7]) begin
         pw_in = (last.ip > 8'sd8) ? (39'(last.m) << 8) : (39'(last.m) << last.ip[3:0]);
      end else begin
         pw_in = (neg > 8'd40) ? 39'd0 : (39'(last.m) >> neg[5:0]);
      end
      qprod_in = 58'(pw_ff) * 58'(bac_pkg::ALT_FULL_DM);
      qsum = qprod_ff + (58'd1 << 29);
      q = qsum[57:30];
      if (sideq_ff.invalid) begin
         alt_in = bac_pkg::ALT_FULL_DM;
      end else if (q > bac_pkg::ALT_SPAN_DM) begin
         alt_in = bac_pkg::ALT_MIN_DM;
      end else begin
         alt_in = bac_pkg::ALT_FULL_DM - q[19:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

@@ tb/baro_altitude_converter_top_test.sv @@
// self-checking testbench for the barometric altitude converter stream block
module baro_altitude_converter_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam longint SPAN_DM = 543300;
   localparam longint FULL_DM = 443300;
   localparam longint FLOOR_DM = -100000;
   localparam longint COEF_Q20 = 199544;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   typedef struct {
      logic [23:0] pressure;
      logic [14:0] temperature;
      logic [19:0] altitude;
      logic        invalid;
   } reading_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // raw_pressure, raw_temperature
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // pressure_q12, temperature_centi, altitude_dm, zero fill
   logic        rsp_tuser;    // pressure_invalid
   logic        csr_valid;
   logic        csr_ready;
   logic [22:0] csr_data;     // reference_pressure

   bit [63:0] log_curve [0:bac_pkg::LOG_TABLE_ENTRIES];
   bit [63:0] root_chain [0:15];
   bit [22:0] sea_level_ref;
   reading_type pending_readings [$];
   int error_count;
   int cycle_count;
   int send_gap_max;
   int take_gap_max;
   int rsp_wait;
   int hold_left;

   baro_altitude_converter_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic bit [63:0] floor_sqrt(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic bit [63:0] log2_mantissa(bit [63:0] x);
      bit [63:0] r;
      r = 0;
      for (int k = 0; k < 17; k++) begin
         x = (x * x) >> 30;
         r = r << 1;
         if (x >= (ONE_Q30 << 1)) begin
            r = r | 1;
            x = x >> 1;
         end
      end
      return (r + 1) >> 1;
   endfunction

   function automatic longint log2_fixed(bit [63:0] v);
      int e;
      bit [63:0] frac, pos, idx, rem, lo, hi;
      e = 0;
      while (e < 23 && (v >> (e + 1)) != 0) e++;
      frac = (v << (30 - e)) & (ONE_Q30 - 1);
      pos = frac * bac_pkg::LOG_TABLE_ENTRIES;
      idx = pos >> 30;
      rem = pos & (ONE_Q30 - 1);
      if (idx >= bac_pkg::LOG_TABLE_ENTRIES) idx = bac_pkg::LOG_TABLE_ENTRIES - 1;
      lo = log_curve[idx];
      hi = log_curve[idx + 1];
      return (longint'(e) << 16) + longint'(lo + (((hi - lo) * rem) >> 30));
   endfunction

   function automatic longint altitude_dm(bit [63:0] p, bit [63:0] p0);
      longint d, alt;
      bit [63:0] u, yq, f, m, pw, q;
      int ip;
      d = log2_fixed(p) - log2_fixed(p0);
      u = 64'(d * COEF_Q20 + (longint'(64) <<< 36));
      yq = (u + (64'd1 << 19)) >> 20;
      ip = int'(yq >> 16) - 64;
      f = yq & 64'hFFFF;
      m = ONE_Q30;
      for (int k = 0; k < 16; k++) begin
         if ((f >> (15 - k)) & 1) m = (m * root_chain[k] + (64'd1 << 29)) >> 30;
      end
      if (ip >= 0) pw = (ip > 8) ? (m << 8) : (m << ip);
      else pw = (ip < -40) ? 0 : (m >> (-ip));
      q = (64'(FULL_DM) * pw + (64'd1 << 29)) >> 30;
      if (q > 64'(SPAN_DM)) return FLOOR_DM;
      alt = FULL_DM - longint'(q);
      if (alt < FLOOR_DM) alt = FLOOR_DM;
      return alt;
   endfunction

   function automatic reading_type convert_sample(logic [39:0] raw, bit [22:0] ref_p);
      reading_type r;
      longint p, t, num, tq, alt;
      p = longint'($signed(raw[23:0]));
      t = longint'($signed(raw[39:24]));
      num = t * 5;
      tq = (num >= 0) ? (num + 12) / 24 : -((-num + 12) / 24);
      tq += 4250;
      r.pressure = raw[23:0];
      r.temperature = tq[14:0];
      r.invalid = (p <= 0);
      alt = (p <= 0) ? FULL_DM : altitude_dm(64'(p), (ref_p == 0) ? 64'd1 : 64'(ref_p));
      r.altitude = alt[19:0];
      return r;
   endfunction

   initial begin
      bit [63:0] s;
      for (int i = 0; i < bac_pkg::LOG_TABLE_ENTRIES; i++)
         log_curve[i] = log2_mantissa(ONE_Q30 +
                                      ((64'(i) << 30) / bac_pkg::LOG_TABLE_ENTRIES));
      log_curve[bac_pkg::LOG_TABLE_ENTRIES] = 65536;
      s = floor_sqrt(64'd1 << 61);
      root_chain[0] = s;
      for (int k = 1; k < 16; k++) root_chain[k] = floor_sqrt(root_chain[k - 1] << 30);
   end

   // sample all handshakes at the rising edge
   always @(posedge clock) begin
      reading_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("baro_altitude_converter_top_test: errors");
         $finish;
      end else if (!reset) begin
         if (csr_valid && csr_ready) sea_level_ref = csr_data;
         if (req_tvalid && req_tready)
            pending_readings.push_back(convert_sample(req_tdata, sea_level_ref));
         if (rsp_tvalid && rsp_tready) begin
            rsp_wait = (take_gap_max > 0) ? $urandom_range(0, take_gap_max) : 0;
            if (pending_readings.size() == 0) begin
               $error("result item with nothing expected");
               error_count++;
            end else begin
               want = pending_readings.pop_front();
               if (rsp_tdata[23:0] !== want.pressure) begin
                  $error("pressure_q12 expected %h got %h", want.pressure, rsp_tdata[23:0]);
                  error_count++;
               end
               if (rsp_tdata[38:24] !== want.temperature) begin
                  $error("temperature_centi expected %h got %h", want.temperature,
                         rsp_tdata[38:24]);
                  error_count++;
               end
               if (rsp_tdata[58:39] !== want.altitude) begin
                  $error("altitude_dm expected %h got %h", want.altitude, rsp_tdata[58:39]);
                  error_count++;
               end
               if (rsp_tuser !== want.invalid) begin
                  $error("pressure_invalid expected %b got %b", want.invalid, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[63:59] !== 5'd0) begin
                  $error("zero fill expected 0 got %h", rsp_tdata[63:59]);
                  error_count++;
               end
            end
         end
      end
   end

   // receiver side stalls
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_sample(logic [23:0] p, logic [15:0] t);
      int gap;
      gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {t, p};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reference(logic [22:0] value);
      drain_pipeline();
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [23:0] plausible_pressure();
      case ($urandom_range(0, 9))
         0: return 24'($urandom);
         1: return 24'(-$signed(24'($urandom_range(0, 8388607))));
         2: return 24'($urandom_range(0, 64));
         3: return 24'($urandom_range(8388000, 8388607));
         default: return 24'($urandom_range(1200000, 4600000));
      endcase
   endfunction

   task automatic test_directed();
      logic [23:0] p_list [12];
      logic [15:0] t_list [10];
      p_list = '{24'd0, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'd1, 24'd2, 24'd4150272,
                 24'd4150271, 24'd4150273, 24'd2457600, 24'd409600, 24'd6000000};
      t_list = '{16'h8000, 16'h7FFF, 16'd0, 16'd1, 16'hFFFF, 16'd12, 16'hFFF4,
                 16'd36, 16'hFFDC, 16'd480};
      for (int i = 0; i < 12; i++) send_sample(p_list[i], t_list[i % 10]);
      for (int i = 0; i < 10; i++) send_sample(24'd4150272, t_list[i]);
      drain_pipeline();
   endtask

   task automatic test_references();
      logic [22:0] refs [5];
      refs = '{23'd1, 23'h7FFFFF, 23'd0, 23'd2048000, 23'd4150272};
      foreach (refs[i]) begin
         write_reference(refs[i]);
         send_sample(24'h7FFFFF, 16'd0);
         send_sample(24'd1, 16'd0);
         send_sample(24'(refs[i]), 16'd100);
         for (int j = 0; j < 40; j++) send_sample(plausible_pressure(), 16'($urandom));
      end
      drain_pipeline();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 250 == 0) begin
            write_reference(($urandom_range(0, 3) == 0) ? 23'($urandom)
                                                       : 23'($urandom_range(3000000, 4500000)));
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
            take_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 18;
         end
         send_sample(plausible_pressure(), 16'($urandom));
      end
      drain_pipeline();
   endtask

   task automatic test_backpressure();
      send_gap_max = 0;
      take_gap_max = 0;
      @(negedge clock);
      hold_left = 300;
      for (int i = 0; i < 80; i++) send_sample(plausible_pressure(), 16'($urandom));
      drain_pipeline();
      send_gap_max = 18;
      take_gap_max = 18;
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      send_gap_max = 18;
      take_gap_max = 18;
      rsp_wait = 0;
      hold_left = 0;
      sea_level_ref = bac_pkg::P0_RESET;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_references();
      test_backpressure();
      test_random(1050);
      write_reference(bac_pkg::P0_RESET);
      if (error_count == 0) begin
         $display("baro_altitude_converter_top_test: clean");
      end else begin
         $display("baro_altitude_converter_top_test: errors");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/bac_pkg.sv
hdl/bac_log2.sv
hdl/bac_pow_cell.sv
hdl/baro_altitude_converter_top.sv
tb/baro_altitude_converter_top_test.sv
